// File: src/awve_pkg.sv
// Package: shared types and constants of the adaptive window velocity estimator.
package awve_pkg;

	localparam int SAMPLE_W = 128;
	localparam int TDATA_W  = 136;
	localparam int CFG_W    = 21;
	localparam int MD_W     = 5;
	localparam int BAND_W   = 21;
	localparam int WIN_W    = 4;
	localparam int DIV_W    = 48;
	localparam int CNT_W    = 6;

	localparam logic [WIN_W-1:0]  WIN_MAX    = 4'd15;
	localparam logic [MD_W-1:0]   DEPTH_RST  = 5'd15;
	localparam logic [BAND_W-1:0] BAND_RST   = 21'd6554;
	localparam logic              REG_DEPTH  = 1'b0;
	localparam logic              REG_BAND   = 1'b1;

	typedef logic [1:0] axis_t;
	localparam axis_t AX_X = 2'd0;
	localparam axis_t AX_Y = 2'd1;
	localparam axis_t AX_Z = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WIN_RD,
		ST_WIN_LD,
		ST_WIN_CHK,
		ST_IN_RD,
		ST_IN_LD,
		ST_IN_CHK,
		ST_AX_PREP,
		ST_AX_MUL,
		ST_AX_CMP,
		ST_VEL_INIT,
		ST_VEL_DIV,
		ST_VEL_ST,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             load_new;
		logic             rd;
		logic             ld_od;
		logic             ld_in;
		logic             prep;
		logic             mul;
		logic             acc_save;
		logic             div_init;
		logic             div_step;
		logic             vel_st;
		logic             out_load;
		logic             res_valid;
		logic [WIN_W-1:0] wlen;
		axis_t            axis;
	} cmd_t;

	typedef struct packed {
		logic dt_zero;
		logic ti_ge;
		logic fit_ok;
		logic div_last;
	} stat_t;

endpackage

// File: src/awve_ram.sv
// Generic single-write, single-read RAM with registered read data.
module awve_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: src/awve_ctrl.sv
// Controller: sequencing of the window search, ring pointers and output handshake.
module awve_ctrl
	import awve_pkg::*;
#(
	parameter int MAX_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic                         cfg_wen,
	input  logic                         cfg_index,
	input  logic [MD_W-1:0]              cfg_depth,
	input  stat_t                        stat,
	output cmd_t                         cmd,
	output logic [$clog2(MAX_DEPTH)-1:0] wr_addr,
	output logic [$clog2(MAX_DEPTH)-1:0] rd_addr
);

	localparam int AW = $clog2(MAX_DEPTH);
	localparam int FW = $clog2(MAX_DEPTH + 1);

	state_t           state_q, state_n;
	logic [AW-1:0]    ws_q;
	logic [FW-1:0]    fill_q, fill_inc;
	logic [MD_W-1:0]  md_q;
	logic [WIN_W-1:0] k_q, k_n, i_q, i_n, best_q, best_n, maxk;
	axis_t            ax_q, ax_n;
	logic             valid_q, valid_n, mv_q;
	logic             do_pass, do_fail;
	logic [WIN_W-1:0] back;
	int               slot, fm;

	function automatic logic [FW-1:0] eff_of(input logic [MD_W-1:0] m);
		logic [FW-1:0] r;
		if (int'(m) < 2) begin
			r = FW'(2);
		end else if (int'(m) > MAX_DEPTH) begin
			r = FW'(MAX_DEPTH);
		end else begin
			r = FW'(m);
		end
		return r;
	endfunction

	assign fill_inc = (fill_q < eff_of(md_q)) ? fill_q + FW'(1) : fill_q;
	assign wr_addr  = ws_q;
	assign m_tvalid = mv_q;

	always_comb begin
		fm   = int'(fill_q) - 1;
		maxk = (fm > 15) ? WIN_MAX : WIN_W'(fm);
		back = (state_q == ST_IN_RD) ? i_q : k_q;
		slot = int'(ws_q) + MAX_DEPTH - 1 - int'(back);
		if (slot >= MAX_DEPTH) begin
			slot = slot - MAX_DEPTH;
		end
		rd_addr = AW'(slot);
	end

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		cmd.axis = ax_q;
		s_tready = 1'b0;
		k_n      = k_q;
		i_n      = i_q;
		ax_n     = ax_q;
		best_n   = best_q;
		valid_n  = valid_q;
		do_pass  = 1'b0;
		do_fail  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_new = 1'b1;
					if (fill_inc < FW'(2)) begin
						valid_n = 1'b0;
						state_n = ST_DONE;
					end else begin
						k_n     = 4'd1;
						state_n = ST_WIN_RD;
					end
				end
			end
			ST_WIN_RD: begin
				cmd.rd  = 1'b1;
				state_n = ST_WIN_LD;
			end
			ST_WIN_LD: begin
				cmd.ld_od = 1'b1;
				state_n   = ST_WIN_CHK;
			end
			ST_WIN_CHK: begin
				if (stat.dt_zero) begin
					do_fail = 1'b1;
				end else if (k_q == 4'd1) begin
					do_pass = 1'b1;
				end else begin
					i_n     = 4'd1;
					state_n = ST_IN_RD;
				end
			end
			ST_IN_RD: begin
				cmd.rd  = 1'b1;
				state_n = ST_IN_LD;
			end
			ST_IN_LD: begin
				cmd.ld_in = 1'b1;
				state_n   = ST_IN_CHK;
			end
			ST_IN_CHK: begin
				if (stat.ti_ge) begin
					do_fail = 1'b1;
				end else begin
					ax_n    = AX_X;
					state_n = ST_AX_PREP;
				end
			end
			ST_AX_PREP: begin
				cmd.prep = 1'b1;
				state_n  = ST_AX_MUL;
			end
			ST_AX_MUL: begin
				cmd.mul = 1'b1;
				state_n = ST_AX_CMP;
			end
			ST_AX_CMP: begin
				if (!stat.fit_ok) begin
					do_fail = 1'b1;
				end else if (ax_q != AX_Z) begin
					ax_n    = ax_q + 2'd1;
					state_n = ST_AX_PREP;
				end else if (i_q + 4'd1 < k_q) begin
					i_n     = i_q + 4'd1;
					state_n = ST_IN_RD;
				end else begin
					do_pass = 1'b1;
				end
			end
			ST_VEL_INIT: begin
				cmd.div_init = 1'b1;
				state_n      = ST_VEL_DIV;
			end
			ST_VEL_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_n = ST_VEL_ST;
				end
			end
			ST_VEL_ST: begin
				cmd.vel_st = 1'b1;
				if (ax_q == AX_Z) begin
					valid_n = 1'b1;
					state_n = ST_DONE;
				end else begin
					ax_n    = ax_q + 2'd1;
					state_n = ST_VEL_INIT;
				end
			end
			ST_DONE: begin
				cmd.res_valid = valid_q;
				cmd.wlen      = valid_q ? best_q : '0;
				if (!mv_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase

		// The longest accepted window is kept; a rejection ends the search.
		if (do_pass) begin
			cmd.acc_save = 1'b1;
			best_n       = k_q;
			if (k_q < maxk) begin
				k_n     = k_q + 4'd1;
				state_n = ST_WIN_RD;
			end else begin
				ax_n    = AX_X;
				state_n = ST_VEL_INIT;
			end
		end
		if (do_fail) begin
			if (k_q == 4'd1) begin
				valid_n = 1'b0;
				state_n = ST_DONE;
			end else begin
				ax_n    = AX_X;
				state_n = ST_VEL_INIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			i_q     <= '0;
			ax_q    <= AX_X;
			best_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			k_q     <= k_n;
			i_q     <= i_n;
			ax_q    <= ax_n;
			best_q  <= best_n;
			valid_q <= valid_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q   <= '0;
			fill_q <= '0;
			md_q   <= DEPTH_RST;
			mv_q   <= 1'b0;
		end else begin
			if (cmd.load_new) begin
				ws_q   <= (int'(ws_q) == MAX_DEPTH - 1) ? '0 : ws_q + AW'(1);
				fill_q <= fill_inc;
			end else if (cfg_wen && cfg_index == REG_DEPTH) begin
				md_q <= cfg_depth;
				if (fill_q > eff_of(cfg_depth)) begin
					fill_q <= eff_of(cfg_depth);
				end
			end
			if (cmd.out_load) begin
				mv_q <= 1'b1;
			end else if (m_tready) begin
				mv_q <= 1'b0;
			end
		end
	end

endmodule

// File: src/awve_dp.sv
// Datapath: sample ring, line-fit band test, velocity divider and result register.
module awve_dp
	import awve_pkg::*;
#(
	parameter int MAX_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmd_t                         cmd,
	output stat_t                        stat,
	input  logic [$clog2(MAX_DEPTH)-1:0] wr_addr,
	input  logic [$clog2(MAX_DEPTH)-1:0] rd_addr,
	input  logic [SAMPLE_W-1:0]          in_data,
	input  logic                         cfg_wen,
	input  logic                         cfg_index,
	input  logic [BAND_W-1:0]            cfg_band,
	output logic [TDATA_W-1:0]           out_data,
	output logic                         out_user
);

	logic [SAMPLE_W-1:0] rd_data;
	logic [31:0]         rd_p [3];
	logic [31:0]         rd_t;
	logic [31:0]         new_p_q [3];
	logic [31:0]         od_p_q [3];
	logic [31:0]         s_p_q [3];
	logic [31:0]         acc_p_q [3];
	logic [31:0]         new_t_q, od_t_q, dt_q, ti_q, acc_dt_q;
	logic [BAND_W-1:0]   band_q;
	logic [31:0]         nsel, osel, ssel, asel;
	logic [32:0]         dp_w, sp_w, mag_w, dpa_w, maga_w;
	logic [33:0]         c_w;
	logic [34:0]         lo_w, hi_w, band_w;
	logic [31:0]         a_q;
	logic [32:0]         lo_q, hi_q;
	logic                negu_q;
	logic [63:0]         p0_w, m1_w, m2_w;
	logic [64:0]         p1_w, p2_w;
	logic [63:0]         p0_q;
	logic [64:0]         p1_q, p2_q;
	logic [31:0]         rem_q;
	logic [DIV_W-1:0]    dvd_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                dneg_q;
	logic [32:0]         rem_sh, rem_sub;
	logic                ge_w;
	logic [31:0]         sat_w;
	logic [31:0]         vel_q [3];

	awve_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_DEPTH)) u_ram (
		.clk     (clk),
		.wr_en   (cmd.load_new),
		.wr_addr (wr_addr),
		.wr_data (in_data),
		.rd_en   (cmd.rd),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rd_p[0] = rd_data[31:0];
	assign rd_p[1] = rd_data[63:32];
	assign rd_p[2] = rd_data[95:64];
	assign rd_t    = rd_data[127:96];

	always_comb begin
		case (cmd.axis)
			AX_Y: begin
				nsel = new_p_q[1];
				osel = od_p_q[1];
				ssel = s_p_q[1];
				asel = acc_p_q[1];
			end
			AX_Z: begin
				nsel = new_p_q[2];
				osel = od_p_q[2];
				ssel = s_p_q[2];
				asel = acc_p_q[2];
			end
			default: begin
				nsel = new_p_q[0];
				osel = od_p_q[0];
				ssel = s_p_q[0];
				asel = acc_p_q[0];
			end
		endcase
	end

	// The line value lies in band exactly when floor(|dp| * ti / dt) falls in
	// [lo, hi], which is checked by comparing products against multiples of dt.
	always_comb begin
		dp_w   = {nsel[31], nsel} - {osel[31], osel};
		sp_w   = {ssel[31], ssel} - {osel[31], osel};
		mag_w  = dp_w[32] ? (~dp_w + 33'd1) : dp_w;
		c_w    = dp_w[32] ? (~{sp_w[32], sp_w} + 34'd1) : {sp_w[32], sp_w};
		band_w = {14'd0, band_q};
		lo_w   = {c_w[33], c_w} - band_w;
		hi_w   = {c_w[33], c_w} + band_w;
		dpa_w  = {nsel[31], nsel} - {asel[31], asel};
		maga_w = dpa_w[32] ? (~dpa_w + 33'd1) : dpa_w;
	end

	assign p0_w = a_q * ti_q;
	assign m1_w = lo_q[31:0] * dt_q;
	assign m2_w = hi_q[31:0] * dt_q;
	assign p1_w = {1'b0, m1_w} + (lo_q[32] ? {1'b0, dt_q, 32'd0} : 65'd0);
	assign p2_w = {1'b0, m2_w} + (hi_q[32] ? {1'b0, dt_q, 32'd0} : 65'd0);

	assign rem_sh  = {rem_q, dvd_q[DIV_W-1]};
	assign rem_sub = rem_sh - {1'b0, acc_dt_q};
	assign ge_w    = rem_sh >= {1'b0, acc_dt_q};

	always_comb begin
		if (dneg_q) begin
			sat_w = (dvd_q >= 48'h0000_8000_0000) ? 32'h8000_0000 : (~dvd_q[31:0] + 32'd1);
		end else begin
			sat_w = (dvd_q > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : dvd_q[31:0];
		end
	end

	assign stat.dt_zero  = (dt_q == 32'd0);
	assign stat.ti_ge    = (ti_q >= dt_q);
	assign stat.fit_ok   = !negu_q && ({1'b0, p0_q} >= p1_q) && ({1'b0, p0_q} < p2_q);
	assign stat.div_last = (cnt_q == CNT_W'(DIV_W - 1));

	always_ff @(posedge clk) begin
		if (cmd.load_new) begin
			new_p_q[0] <= in_data[31:0];
			new_p_q[1] <= in_data[63:32];
			new_p_q[2] <= in_data[95:64];
			new_t_q    <= in_data[127:96];
		end
		if (cmd.ld_od) begin
			od_p_q <= rd_p;
			od_t_q <= rd_t;
			dt_q   <= new_t_q - rd_t;
		end
		if (cmd.ld_in) begin
			s_p_q <= rd_p;
			ti_q  <= rd_t - od_t_q;
		end
		if (cmd.acc_save) begin
			acc_p_q  <= od_p_q;
			acc_dt_q <= dt_q;
		end
		if (cmd.prep) begin
			a_q    <= mag_w[31:0];
			lo_q   <= lo_w[34] ? 33'd0 : lo_w[32:0];
			hi_q   <= hi_w[32:0] + 33'd1;
			negu_q <= hi_w[34];
		end
		if (cmd.mul) begin
			p0_q <= p0_w;
			p1_q <= p1_w;
			p2_q <= p2_w;
		end
		if (cmd.div_init) begin
			dvd_q  <= {maga_w[31:0], 16'd0};
			rem_q  <= '0;
			dneg_q <= dpa_w[32];
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[DIV_W-2:0], ge_w};
			rem_q <= ge_w ? rem_sub[31:0] : rem_sh[31:0];
		end
		if (cmd.vel_st) begin
			case (cmd.axis)
				AX_Y:    vel_q[1] <= sat_w;
				AX_Z:    vel_q[2] <= sat_w;
				default: vel_q[0] <= sat_w;
			endcase
		end
		if (cmd.out_load) begin
			out_data <= {4'd0, new_t_q, cmd.wlen,
				cmd.res_valid ? vel_q[2] : 32'd0,
				cmd.res_valid ? vel_q[1] : 32'd0,
				cmd.res_valid ? vel_q[0] : 32'd0};
			out_user <= cmd.res_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q <= BAND_RST;
			cnt_q  <= '0;
		end else begin
			if (cfg_wen && cfg_index == REG_BAND) begin
				band_q <= cfg_band;
			end
			if (cmd.div_init) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

endmodule

// File: src/adaptive_window_velocity_estimator_core.sv
// Top level of the adaptive window velocity estimator.
//
// The slave stream takes one timestamped 3-D position per beat. The block
// stores it in a ring of the most recent samples, grows a window backwards
// from the newest sample while every inner sample stays within band of the
// line through the window ends, and returns one result beat per input beat:
// per-axis velocity of the longest accepted window, its length, the echoed
// stamp, and a valid flag in tuser.
// One item is processed at a time; a new beat is taken only when the search
// for the previous one has finished. An invalid result is given when fewer
// than two samples are stored or when the shortest window is rejected. The
// inner-sample test runs one axis at a time through three multipliers, and
// the velocity uses a 48-step restoring divider per axis. The result sits
// in an output register; if the master side stalls, the next input beat is
// still taken and worked on, and its result waits until the register is
// free. Reset empties the ring and restores the default depth and band.
// Configuration writes go through the plain write port.
module adaptive_window_velocity_estimator_core
	import awve_pkg::*;
#(
	parameter int MAX_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// pos_x, pos_y, pos_z, stamp
	input  logic [SAMPLE_W-1:0] s_axis_tdata,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// vel_x, vel_y, vel_z, window_len, out_stamp, zero fill
	output logic [TDATA_W-1:0]  m_axis_tdata,
	// valid_res
	output logic                m_axis_tuser,
	input  logic                cfg_wen,
	input  logic                cfg_index,
	input  logic [CFG_W-1:0]    cfg_data
);

	cmd_t                         cmd;
	stat_t                        stat;
	logic [$clog2(MAX_DEPTH)-1:0] wr_addr;
	logic [$clog2(MAX_DEPTH)-1:0] rd_addr;

	awve_ctrl #(.MAX_DEPTH(MAX_DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_axis_tvalid),
		.s_tready  (s_axis_tready),
		.m_tvalid  (m_axis_tvalid),
		.m_tready  (m_axis_tready),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_depth (cfg_data[MD_W-1:0]),
		.stat      (stat),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr)
	);

	awve_dp #(.MAX_DEPTH(MAX_DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr),
		.in_data   (s_axis_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_band  (cfg_data[BAND_W-1:0]),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

endmodule
